FILE: hw/rtl/lqrsf_pkg.sv
package lqrsf_pkg;

    // field and datapath widths
    localparam int STATE_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int ERR_W       = STATE_W + 1;
    localparam int PROD_W      = GAIN_W + ERR_W;
    localparam int TORQ_W      = PROD_W + 4;
    localparam int MAG_W       = TORQ_W - 1;
    localparam int INV_W       = 18;
    localparam int SCALED_W    = MAG_W + INV_W;
    localparam int RAD_SHIFT   = 4;
    localparam int RAD_W       = SCALED_W - RAD_SHIFT;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int LIM_W       = 16;
    localparam int SPEED_W     = LIM_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;

    // pipeline depth: front end, one stage per root bit, output stage
    localparam int FRONT_STAGES = 5;
    localparam int LATENCY      = FRONT_STAGES + ROOT_W + 1;

    // register reset values
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_PEND_ANGLE = 16'sd3442;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_PEND_RATE  = 16'sd589;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_YAW_ANGLE  = 16'sd57;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN_YAW_RATE   = 16'sd334;
    localparam logic signed [STATE_W-1:0] RST_SETPOINT        = 16'sd0;
    localparam logic [INV_W-1:0]          RST_INV_THRUST      = 18'd116978;
    localparam logic [LIM_W-1:0]          RST_SPEED_LIMIT     = 16'd51200;

    // register index map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PEND_ANGLE     = 3'd0,
        REG_GAIN_PEND_RATE      = 3'd1,
        REG_GAIN_YAW_ANGLE      = 3'd2,
        REG_GAIN_YAW_RATE       = 3'd3,
        REG_SETPOINT_PEND_ANGLE = 3'd4,
        REG_SETPOINT_YAW_ANGLE  = 3'd5,
        REG_INV_THRUST_CONST    = 3'd6,
        REG_SPEED_LIMIT         = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [STATE_W-1:0] pend_angle;
        logic signed [STATE_W-1:0] pend_rate;
        logic signed [STATE_W-1:0] yaw_angle;
        logic signed [STATE_W-1:0] yaw_rate;
    } in_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] motor_speed;
        logic                      clamped;
    } out_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_pend_angle;
        logic signed [GAIN_W-1:0]  gain_pend_rate;
        logic signed [GAIN_W-1:0]  gain_yaw_angle;
        logic signed [GAIN_W-1:0]  gain_yaw_rate;
        logic signed [STATE_W-1:0] setpoint_pend_angle;
        logic signed [STATE_W-1:0] setpoint_yaw_angle;
        logic [INV_W-1:0]          inv_thrust_const;
        logic [LIM_W-1:0]          speed_limit;
    } cfg_t;

    // control that travels with each beat
    typedef struct packed {
        logic vld;
        logic neg;
    } ctl_t;

endpackage

FILE: hw/rtl/lqrsf_gain.sv
module lqrsf_gain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  lqrsf_pkg::in_t                sample,
    input  lqrsf_pkg::cfg_t               cfg,
    output lqrsf_pkg::ctl_t               ctl,
    output logic [lqrsf_pkg::RAD_W-1:0]   rad
);
    import lqrsf_pkg::*;

    logic                      vld1_reg, vld2_reg, vld3_reg;
    ctl_t                      ctl4_reg, ctl5_reg;
    ctl_t                      ctl4_next;

    logic signed [ERR_W-1:0]   err_pa_reg, err_pr_reg, err_ya_reg, err_yr_reg;
    logic signed [ERR_W-1:0]   err_pa_next, err_pr_next, err_ya_next, err_yr_next;
    logic signed [PROD_W-1:0]  p_pa_reg, p_pr_reg, p_ya_reg, p_yr_reg;
    logic signed [PROD_W-1:0]  p_pa_next, p_pr_next, p_ya_next, p_yr_next;
    logic signed [TORQ_W-1:0]  torque_reg, torque_next, torque_abs;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic [SCALED_W-1:0]       scaled;
    logic [RAD_W-1:0]          rad_reg, rad_next;

    // stage 1: state errors against setpoints
    always_comb
    begin
        err_pa_next = ERR_W'(cfg.setpoint_pend_angle) - ERR_W'(sample.pend_angle);
        err_pr_next = ERR_W'(0) - ERR_W'(sample.pend_rate);
        err_ya_next = ERR_W'(cfg.setpoint_yaw_angle) - ERR_W'(sample.yaw_angle);
        err_yr_next = ERR_W'(0) - ERR_W'(sample.yaw_rate);
    end

    // stage 2: one gain product per state
    always_comb
    begin
        p_pa_next = PROD_W'(cfg.gain_pend_angle) * PROD_W'(err_pa_reg);
        p_pr_next = PROD_W'(cfg.gain_pend_rate) * PROD_W'(err_pr_reg);
        p_ya_next = PROD_W'(cfg.gain_yaw_angle) * PROD_W'(err_ya_reg);
        p_yr_next = PROD_W'(cfg.gain_yaw_rate) * PROD_W'(err_yr_reg);
    end

    // stage 3: torque sum, rate terms scaled up to the angle format
    assign torque_next = TORQ_W'(p_pa_reg) + TORQ_W'(p_ya_reg)
                       + ((TORQ_W'(p_pr_reg) + TORQ_W'(p_yr_reg)) <<< 2);

    // stage 4: sign and magnitude
    always_comb
    begin
        torque_abs    = torque_reg[TORQ_W-1] ? -torque_reg : torque_reg;
        mag_next      = torque_abs[MAG_W-1:0];
        ctl4_next.vld = vld3_reg;
        ctl4_next.neg = torque_reg[TORQ_W-1];
    end

    // stage 5: scale by the thrust reciprocal, drop four fraction bits
    assign scaled   = SCALED_W'(mag_reg) * SCALED_W'(cfg.inv_thrust_const);
    assign rad_next = scaled[SCALED_W-1:RAD_SHIFT];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            ctl4_reg <= ctl4_next;
            ctl5_reg <= ctl4_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        err_pa_reg <= err_pa_next;
        err_pr_reg <= err_pr_next;
        err_ya_reg <= err_ya_next;
        err_yr_reg <= err_yr_next;
        p_pa_reg   <= p_pa_next;
        p_pr_reg   <= p_pr_next;
        p_ya_reg   <= p_ya_next;
        p_yr_reg   <= p_yr_next;
        torque_reg <= torque_next;
        mag_reg    <= mag_next;
        rad_reg    <= rad_next;
    end

    assign ctl = ctl5_reg;
    assign rad = rad_reg;

    // a beat passes the front-end valid registers vld1, vld2, vld3, ctl4 and ctl5 in turn
    a_front_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ctl5_reg.vld |-> $past(in_vld, FRONT_STAGES))
        else $error("front end valid out of step");

endmodule

FILE: hw/rtl/lqrsf_sqrt.sv
module lqrsf_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lqrsf_pkg::ctl_t               ctl_in,
    input  logic [lqrsf_pkg::RAD_W-1:0]   rad_in,
    output lqrsf_pkg::ctl_t               ctl_out,
    output logic [lqrsf_pkg::ROOT_W-1:0]  root_out
);
    import lqrsf_pkg::*;

    // stage inputs (index 0 is the module input) and stage registers
    ctl_t               ctl_s    [0:ROOT_W-1];
    logic [RAD_W-1:0]   rad_s    [0:ROOT_W-1];
    logic [REM_W-1:0]   rem_s    [0:ROOT_W-1];
    logic [ROOT_W-1:0]  root_s   [0:ROOT_W-1];

    ctl_t               ctl_reg  [0:ROOT_W-1];
    logic [RAD_W-1:0]   rad_reg  [0:ROOT_W-1];
    logic [REM_W-1:0]   rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0]  root_reg [0:ROOT_W-1];

    // one root bit per stage, restoring digit recurrence
    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_stage
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (g == 0)
        begin : g_first
            assign ctl_s[g]  = ctl_in;
            assign rad_s[g]  = rad_in;
            assign rem_s[g]  = '0;
            assign root_s[g] = '0;
        end
        else
        begin : g_chain
            assign ctl_s[g]  = ctl_reg[g-1];
            assign rad_s[g]  = rad_reg[g-1];
            assign rem_s[g]  = rem_reg[g-1];
            assign root_s[g] = root_reg[g-1];
        end

        // bring down the next radicand bit pair and try the next root bit
        always_comb
        begin
            rem_sh   = {rem_s[g][REM_W-3:0], rad_s[g][RAD_W-1 -: 2]};
            trial    = {1'b0, root_s[g], 2'b01};
            rad_next = {rad_s[g][RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_s[g][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_s[g][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
            end
            else
            begin
                ctl_reg[g] <= ctl_s[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[g]  <= rad_next;
            rem_reg[g]  <= rem_next;
            root_reg[g] <= root_next;
        end
    end

    assign ctl_out  = ctl_reg[ROOT_W-1];
    assign root_out = root_reg[ROOT_W-1];

    // valid and sign come out of the last stage unchanged, one stage per bit
    a_sqrt_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_out.vld |-> $past(ctl_in.vld, ROOT_W))
        else $error("root pipeline valid out of step");

    a_sqrt_sign: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_out.vld |-> ctl_out.neg == $past(ctl_in.neg, ROOT_W))
        else $error("root pipeline sign out of step");

endmodule

FILE: hw/rtl/lqrsf_clamp.sv
module lqrsf_clamp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lqrsf_pkg::ctl_t               ctl_in,
    input  logic [lqrsf_pkg::ROOT_W-1:0]  root,
    input  logic [lqrsf_pkg::LIM_W-1:0]   speed_limit,
    output logic                          done,
    output lqrsf_pkg::out_t               result
);
    import lqrsf_pkg::*;

    logic                done_reg;
    out_t                result_reg, result_next;
    logic                over;
    logic [LIM_W-1:0]    mag_sel;
    logic [SPEED_W-1:0]  mag_ext;

    // saturate the magnitude, then restore the sign
    always_comb
    begin
        over                    = root > ROOT_W'(speed_limit);
        mag_sel                 = over ? speed_limit : root[LIM_W-1:0];
        mag_ext                 = SPEED_W'(mag_sel);
        result_next.motor_speed = ctl_in.neg ? -signed'(mag_ext) : signed'(mag_ext);
        result_next.clamped     = over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a clamped beat carries exactly the limit, with either sign
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.clamped |->
            (result_reg.motor_speed == signed'(SPEED_W'(speed_limit)))
         || (result_reg.motor_speed == -signed'(SPEED_W'(speed_limit))))
        else $error("clamped speed differs from limit");

endmodule

FILE: hw/rtl/lqr_state_feedback_motor_speed.sv
// lqr full state feedback controller, one signed motor speed per sample
//
// input: a sample beat (pend_angle, pend_rate, yaw_angle, yaw_rate) is taken
// at each rising edge with start high and busy low. busy stays low, so a new
// sample may be offered every cycle.
// output: done is high for one cycle with result (motor_speed, clamped); the
// beat is taken at the edge that ends that cycle and cannot be held off.
// pipeline: a sample passes five front-end stages (errors, gain products,
// torque sum, magnitude, thrust scaling), 25 square root stages (one root
// bit each) and one saturation stage before its result appears with done.
// throughput: one sample per cycle, set by the fully pipelined square root.
// configuration: cfg_we with cfg_index and cfg_data writes a register at the
// clock edge; write only while no sample is in flight.
// reset: rst_n clears every valid bit, so no stale beat appears, and loads
// the registers with their default gains, setpoints and limits.
module lqr_state_feedback_motor_speed (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  lqrsf_pkg::in_t                    sample,
    output logic                              done,
    output lqrsf_pkg::out_t                   result,
    input  logic                              cfg_we,
    input  logic [lqrsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lqrsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lqrsf_pkg::*;

    cfg_t                cfg_reg, cfg_next;
    logic                accept;
    ctl_t                ctl_front, ctl_root;
    logic [RAD_W-1:0]    rad;
    logic [ROOT_W-1:0]   root;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_PEND_ANGLE:     cfg_next.gain_pend_angle     = cfg_data[GAIN_W-1:0];
                REG_GAIN_PEND_RATE:      cfg_next.gain_pend_rate      = cfg_data[GAIN_W-1:0];
                REG_GAIN_YAW_ANGLE:      cfg_next.gain_yaw_angle      = cfg_data[GAIN_W-1:0];
                REG_GAIN_YAW_RATE:       cfg_next.gain_yaw_rate       = cfg_data[GAIN_W-1:0];
                REG_SETPOINT_PEND_ANGLE: cfg_next.setpoint_pend_angle = cfg_data[STATE_W-1:0];
                REG_SETPOINT_YAW_ANGLE:  cfg_next.setpoint_yaw_angle  = cfg_data[STATE_W-1:0];
                REG_INV_THRUST_CONST:    cfg_next.inv_thrust_const    = cfg_data[INV_W-1:0];
                REG_SPEED_LIMIT:         cfg_next.speed_limit         = cfg_data[LIM_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_pend_angle     <= RST_GAIN_PEND_ANGLE;
            cfg_reg.gain_pend_rate      <= RST_GAIN_PEND_RATE;
            cfg_reg.gain_yaw_angle      <= RST_GAIN_YAW_ANGLE;
            cfg_reg.gain_yaw_rate       <= RST_GAIN_YAW_RATE;
            cfg_reg.setpoint_pend_angle <= RST_SETPOINT;
            cfg_reg.setpoint_yaw_angle  <= RST_SETPOINT;
            cfg_reg.inv_thrust_const    <= RST_INV_THRUST;
            cfg_reg.speed_limit         <= RST_SPEED_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // torque and radicand
    lqrsf_gain u_gain (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (accept),
        .sample (sample),
        .cfg    (cfg_reg),
        .ctl    (ctl_front),
        .rad    (rad)
    );

    // integer square root
    lqrsf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (ctl_front),
        .rad_in   (rad),
        .ctl_out  (ctl_root),
        .root_out (root)
    );

    // saturation and output register
    lqrsf_clamp u_clamp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_in      (ctl_root),
        .root        (root),
        .speed_limit (cfg_reg.speed_limit),
        .done        (done),
        .result      (result)
    );

    // every result beat answers a sample taken a fixed time earlier
    a_end_to_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result beat without matching sample");

    a_sample_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept, LATENCY) && $past(rst_n, LATENCY) |-> done)
        else $error("sample beat lost");

endmodule

FILE: sim/tb_lqr_state_feedback_motor_speed.sv
`timescale 1ns / 1ps

module tb_lqr_state_feedback_motor_speed;

    import lqrsf_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 7;
    localparam int NUM_REGS        = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 150;

    localparam logic [STATE_W-1:0] S_MAX = 16'h7FFF;
    localparam logic [STATE_W-1:0] S_MIN = 16'h8000;

    // expected motor speeds and a mirror of the register file
    class speed_scoreboard;
        out_t speed_q[$];
        cfg_t regs;
        int   n_checked;
        int   n_errors;

        function new();
            regs.gain_pend_angle     = RST_GAIN_PEND_ANGLE;
            regs.gain_pend_rate      = RST_GAIN_PEND_RATE;
            regs.gain_yaw_angle      = RST_GAIN_YAW_ANGLE;
            regs.gain_yaw_rate       = RST_GAIN_YAW_RATE;
            regs.setpoint_pend_angle = RST_SETPOINT;
            regs.setpoint_yaw_angle  = RST_SETPOINT;
            regs.inv_thrust_const    = RST_INV_THRUST;
            regs.speed_limit         = RST_SPEED_LIMIT;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        // 16 bit registers keep only the low bits of the write data
        function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_GAIN_PEND_ANGLE:     regs.gain_pend_angle     = d[GAIN_W-1:0];
                REG_GAIN_PEND_RATE:      regs.gain_pend_rate      = d[GAIN_W-1:0];
                REG_GAIN_YAW_ANGLE:      regs.gain_yaw_angle      = d[GAIN_W-1:0];
                REG_GAIN_YAW_RATE:       regs.gain_yaw_rate       = d[GAIN_W-1:0];
                REG_SETPOINT_PEND_ANGLE: regs.setpoint_pend_angle = d[STATE_W-1:0];
                REG_SETPOINT_YAW_ANGLE:  regs.setpoint_yaw_angle  = d[STATE_W-1:0];
                REG_INV_THRUST_CONST:    regs.inv_thrust_const    = d[INV_W-1:0];
                REG_SPEED_LIMIT:         regs.speed_limit         = d[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // torque sum, exact square root, then saturation
        function out_t motor_speed_of(in_t s);
            longint pa, pr, ya, yr;
            longint ga, gr, gy, gw, spa, sya;
            longint torque;
            longint unsigned mag_u, inv, rad, root, bitv, lim;
            logic [63:0] spd;
            logic neg;
            out_t r;
            pa  = s.pend_angle;
            pr  = s.pend_rate;
            ya  = s.yaw_angle;
            yr  = s.yaw_rate;
            ga  = regs.gain_pend_angle;
            gr  = regs.gain_pend_rate;
            gy  = regs.gain_yaw_angle;
            gw  = regs.gain_yaw_rate;
            spa = regs.setpoint_pend_angle;
            sya = regs.setpoint_yaw_angle;
            inv = regs.inv_thrust_const;
            lim = regs.speed_limit;

            // rate setpoints are zero; rates carry two fewer fraction bits
            torque = ga * (spa - pa) + gy * (sya - ya) + 4 * (gr * (0 - pr) + gw * (0 - yr));
            neg = (torque < 0);
            if (neg)
                mag_u = -torque;
            else
                mag_u = torque;
            rad = (mag_u * inv) >> RAD_SHIFT;

            // bitwise integer square root
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rad)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rad >= root + bitv)
                begin
                    rad  = rad - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end

            r.clamped = 1'b0;
            if (root > lim)
            begin
                root      = lim;
                r.clamped = 1'b1;
            end
            spd = root;
            if (neg)
                spd = -root;
            r.motor_speed = spd[SPEED_W-1:0];
            return r;
        endfunction

        function void note_sample(in_t s);
            speed_q.push_back(motor_speed_of(s));
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (speed_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: result beat with nothing expected: motor_speed %0d clamped %0b",
                             $time, got.motor_speed, got.clamped);
                return;
            end
            want = speed_q.pop_front();
            n_checked++;
            if (got.motor_speed !== want.motor_speed)
            begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: motor_speed mismatch: expected %0d, actual %0d",
                             $time, want.motor_speed, got.motor_speed);
            end
            if (got.clamped !== want.clamped)
            begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: clamped mismatch: expected %0b, actual %0b",
                             $time, want.clamped, got.clamped);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_t                   sample;
    logic                  done;
    out_t                  result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    speed_scoreboard sb = new();
    int n_samples    = 0;
    int n_settings   = 0;
    int stall_cycles = 0;

    lqr_state_feedback_motor_speed u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // monitor: sample beats go to the predictor, result beats get checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_sample(sample);
                n_samples++;
            end
            if (done)
                sb.check_result(result);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, stall_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic in_t mk_sample(input logic [STATE_W-1:0] pa, pr, ya, yr);
        in_t s;
        s.pend_angle = pa;
        s.pend_rate  = pr;
        s.yaw_angle  = ya;
        s.yaw_rate   = yr;
        return s;
    endfunction

    // mix of full range, near zero and extreme values
    function automatic logic [STATE_W-1:0] rand_state();
        logic [STATE_W-1:0] v;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            v = STATE_W'($urandom);
        else if (pick < 85)
            v = STATE_W'($urandom_range(1023)) - 16'd512;
        else
        begin
            case ($urandom_range(4))
                0:       v = S_MIN;
                1:       v = S_MAX;
                2:       v = '0;
                3:       v = '1;
                default: v = 16'd1;
            endcase
        end
        return v;
    endfunction

    // random settings, thrust reciprocal mostly small so not everything clamps
    function automatic cfg_t random_settings();
        cfg_t c;
        c.gain_pend_angle     = GAIN_W'($urandom);
        c.gain_pend_rate      = GAIN_W'($urandom);
        c.gain_yaw_angle      = GAIN_W'($urandom);
        c.gain_yaw_rate       = GAIN_W'($urandom);
        c.setpoint_pend_angle = STATE_W'($urandom);
        c.setpoint_yaw_angle  = STATE_W'($urandom);
        if ($urandom_range(1))
            c.inv_thrust_const = INV_W'($urandom_range(4096, 1));
        else
            c.inv_thrust_const = INV_W'($urandom_range(262143, 1));
        c.speed_limit = LIM_W'($urandom);
        return c;
    endfunction

    // one sample beat, with random idle cycles ahead of it
    task automatic send_sample(input in_t s, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start  <= 1'b0;
            sample <= in_t'({$urandom, $urandom});
            @(posedge clk);
        end
        start  <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // wait until every expected result has come out
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (sb.speed_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // write all registers, junk in the unused data bits
    task automatic load_settings(input cfg_t c);
        logic [CFG_DATA_W-1:0] d;
        reg_index_t idx;
        drain_pipeline();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            idx = reg_index_t'(i);
            d   = CFG_DATA_W'($urandom);
            case (idx)
                REG_GAIN_PEND_ANGLE:     d[GAIN_W-1:0]  = c.gain_pend_angle;
                REG_GAIN_PEND_RATE:      d[GAIN_W-1:0]  = c.gain_pend_rate;
                REG_GAIN_YAW_ANGLE:      d[GAIN_W-1:0]  = c.gain_yaw_angle;
                REG_GAIN_YAW_RATE:       d[GAIN_W-1:0]  = c.gain_yaw_rate;
                REG_SETPOINT_PEND_ANGLE: d[STATE_W-1:0] = c.setpoint_pend_angle;
                REG_SETPOINT_YAW_ANGLE:  d[STATE_W-1:0] = c.setpoint_yaw_angle;
                REG_INV_THRUST_CONST:    d              = c.inv_thrust_const;
                REG_SPEED_LIMIT:         d[LIM_W-1:0]   = c.speed_limit;
                default: ;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= d;
            sb.write_reg(idx, d);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // stimulus
    initial
    begin
        cfg_t c;
        in_t  s;
        int   idle_pct;
        rst_n     = 1'b0;
        start     = 1'b0;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero torque and field extremes
        send_sample(mk_sample(0, 0, 0, 0), 0);
        send_sample(mk_sample(S_MAX, 0, 0, 0), 0);
        send_sample(mk_sample(S_MIN, 0, 0, 0), 0);
        send_sample(mk_sample(0, S_MAX, 0, 0), 0);
        send_sample(mk_sample(0, S_MIN, 0, 0), 0);
        send_sample(mk_sample(0, 0, S_MAX, 0), 0);
        send_sample(mk_sample(0, 0, S_MIN, 0), 0);
        send_sample(mk_sample(0, 0, 0, S_MAX), 0);
        send_sample(mk_sample(0, 0, 0, S_MIN), 0);
        send_sample(mk_sample(S_MAX, S_MAX, S_MAX, S_MAX), 0);
        send_sample(mk_sample(S_MIN, S_MIN, S_MIN, S_MIN), 0);

        // unit gain on roll angle: speed of exactly 1024 for a 1 rad error
        c = '0;
        c.gain_pend_angle  = 16'sd256;
        c.inv_thrust_const = 18'd16;
        c.speed_limit      = 16'd1024;
        load_settings(c);
        send_sample(mk_sample(-4096, 0, 0, 0), 0);
        send_sample(mk_sample(4096, 0, 0, 0), 0);

        // limit one below: clamp in both directions
        c.speed_limit = 16'd1023;
        load_settings(c);
        send_sample(mk_sample(-4096, 0, 0, 0), 0);
        send_sample(mk_sample(4096, 0, 0, 0), 0);

        // zero limit: nonzero speed clamps to zero
        c.speed_limit = 16'd0;
        load_settings(c);
        send_sample(mk_sample(-4096, 0, 0, 0), 0);
        send_sample(mk_sample(0, 0, 0, 0), 0);
        send_sample(mk_sample(1, 0, 0, 0), 0);

        // zero thrust reciprocal: speed is zero
        c.speed_limit      = 16'd1024;
        c.inv_thrust_const = 18'd0;
        load_settings(c);
        send_sample(mk_sample(-4096, 0, 0, 0), 0);
        send_sample(mk_sample(S_MIN, S_MAX, S_MIN, S_MAX), 0);

        // random phases over several settings and sender gap rates
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            c = random_settings();
            case (p)
                0:
                begin
                    c.gain_pend_angle     = RST_GAIN_PEND_ANGLE;
                    c.gain_pend_rate      = RST_GAIN_PEND_RATE;
                    c.gain_yaw_angle      = RST_GAIN_YAW_ANGLE;
                    c.gain_yaw_rate       = RST_GAIN_YAW_RATE;
                    c.setpoint_pend_angle = RST_SETPOINT;
                    c.setpoint_yaw_angle  = RST_SETPOINT;
                    c.inv_thrust_const    = RST_INV_THRUST;
                    c.speed_limit         = RST_SPEED_LIMIT;
                end
                1:
                begin
                    c.gain_pend_angle     = S_MAX;
                    c.gain_pend_rate      = S_MAX;
                    c.gain_yaw_angle      = S_MAX;
                    c.gain_yaw_rate       = S_MAX;
                    c.setpoint_pend_angle = S_MAX;
                    c.setpoint_yaw_angle  = S_MAX;
                    c.inv_thrust_const    = 18'd262143;
                    c.speed_limit         = 16'd65535;
                end
                2:
                begin
                    c.gain_pend_angle     = S_MIN;
                    c.gain_pend_rate      = S_MIN;
                    c.gain_yaw_angle      = S_MIN;
                    c.gain_yaw_rate       = S_MIN;
                    c.setpoint_pend_angle = S_MIN;
                    c.setpoint_yaw_angle  = S_MIN;
                    c.inv_thrust_const    = 18'd1;
                    c.speed_limit         = 16'd65535;
                end
                4: c.speed_limit = 16'd0;
                6: c.speed_limit = LIM_W'($urandom_range(255));
                default: ;
            endcase
            load_settings(c);

            case (p % 4)
                1:       idle_pct = 73;
                3:       idle_pct = 34;
                default: idle_pct = 0;
            endcase

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                s = mk_sample(rand_state(), rand_state(), rand_state(), rand_state());
                send_sample(s, idle_pct);
            end
        end

        drain_pipeline();
        $display("run covered %0d sample beats and %0d checked speed results",
                 n_samples, sb.n_checked);
        $display("over %0d register settings, sender gaps at 0, 34 and 73 percent",
                 n_settings);
        if (sb.n_errors == 0 && sb.speed_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: lqr_state_feedback_motor_speed.f
hw/rtl/lqrsf_pkg.sv
hw/rtl/lqrsf_gain.sv
hw/rtl/lqrsf_sqrt.sv
hw/rtl/lqrsf_clamp.sv
hw/rtl/lqr_state_feedback_motor_speed.sv
sim/tb_lqr_state_feedback_motor_speed.sv
